// File: rtl/core/chinese_number_speech_tokens_defines.svh
// Assertion macros for the numeral reader checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef CHINESE_NUMBER_SPEECH_TOKENS_DEFINES_SVH
`define CHINESE_NUMBER_SPEECH_TOKENS_DEFINES_SVH

// check on every edge outside reset
`define CNST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every edge, reset included
`define CNST_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/cnst_pkg.sv
// Package for the Chinese numeral reader: clip codes, slot order, digit types.
// No dependencies; used by cnst_split, the top level and the checker.
`default_nettype none

package cnst_pkg;

    localparam int unsigned VALUE_W  = 15;
    localparam int unsigned MAG_W    = 14;
    localparam int unsigned CLIP_W   = 8;
    localparam int unsigned NSTAGE   = 8;
    localparam int unsigned NSLOT    = 11;
    localparam int unsigned SLOT_W   = 4;

    localparam logic [CLIP_W-1:0] CLIP_DIGIT0   = 8'd100;
    localparam logic [CLIP_W-1:0] CLIP_TEN      = 8'd110;
    localparam logic [CLIP_W-1:0] CLIP_HUNDRED  = 8'd111;
    localparam logic [CLIP_W-1:0] CLIP_THOUSAND = 8'd112;
    localparam logic [CLIP_W-1:0] CLIP_NEGATIVE = 8'd122;

    localparam logic [MAG_W-1:0] MAG_LIMIT = 14'd9999;

    // reciprocals, exact over the magnitude range
    localparam logic [14:0] RECIP_1000 = 15'd16778;
    localparam logic [5:0]  RECIP_100  = 6'd41;
    localparam logic [7:0]  RECIP_10   = 8'd205;

    // emission order of clips
    localparam logic [SLOT_W-1:0] SLOT_NEG  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_ZERO = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_TH_D = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_TH_U = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_GAP1 = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_HU_D = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_HU_U = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_GAP2 = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_TE_D = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_TE_U = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_ON_D = 4'd10;

    typedef struct packed {
        logic [3:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [3:0] on;
    } t_digits;

    typedef struct packed {
        t_digits          dig;
        logic [NSLOT-1:0] mask;
    } t_item;

    function automatic logic [CLIP_W-1:0] slot_clip(logic [SLOT_W-1:0] idx, t_digits d);
        logic [CLIP_W-1:0] c;
        case (idx)
            SLOT_NEG:  c = CLIP_NEGATIVE;
            SLOT_ZERO: c = CLIP_DIGIT0;
            SLOT_TH_D: c = CLIP_DIGIT0 + CLIP_W'(d.th);
            SLOT_TH_U: c = CLIP_THOUSAND;
            SLOT_GAP1: c = CLIP_DIGIT0;
            SLOT_HU_D: c = CLIP_DIGIT0 + CLIP_W'(d.hu);
            SLOT_HU_U: c = CLIP_HUNDRED;
            SLOT_GAP2: c = CLIP_DIGIT0;
            SLOT_TE_D: c = CLIP_DIGIT0 + CLIP_W'(d.te);
            SLOT_TE_U: c = CLIP_TEN;
            SLOT_ON_D: c = CLIP_DIGIT0 + CLIP_W'(d.on);
            default:   c = CLIP_DIGIT0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cnst_split.sv
// Eight-stage pipeline: sign and magnitude, saturation, decimal digits, clip mask.
// Depends on cnst_pkg.
`default_nettype none

module cnst_split import cnst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output t_item              o_item
);

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] w_rdy;

    logic              r1_neg, r2_neg, r3_neg, r4_neg, r5_neg, r6_neg, r7_neg;
    logic [VALUE_W-1:0] r1_mag;
    logic [MAG_W-1:0]  r2_mag, r3_mag;
    logic [3:0]        r3_th, r4_th, r5_th, r6_th, r7_th;
    logic [9:0]        r4_r1, r5_r1;
    logic [3:0]        r5_hu, r6_hu, r7_hu;
    logic [6:0]        r6_r2, r7_r2;
    logic [3:0]        r7_te;
    t_item             r8_item;

    logic [VALUE_W-1:0] w_abs;
    logic [28:0]       w_p3;
    logic [MAG_W-1:0]  w_sub4;
    logic [15:0]       w_p5;
    logic [9:0]        w_sub6;
    logic [14:0]       w_p7;
    logic [6:0]        w_sub8;
    logic [3:0]        w_on;
    logic [NSLOT-1:0]  w_mask;

    always_comb begin
        w_rdy[NSTAGE-1] = !r_v[NSTAGE-1] || i_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign w_abs  = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
    assign w_p3   = 29'(r2_mag) * 29'(RECIP_1000);
    assign w_sub4 = r3_mag - 14'(r3_th) * 14'd1000;
    assign w_p5   = 16'(r4_r1) * 16'(RECIP_100);
    assign w_sub6 = r5_r1 - 10'(r5_hu) * 10'd100;
    assign w_p7   = 15'(r6_r2) * 15'(RECIP_10);
    assign w_sub8 = r7_r2 - 7'(r7_te) * 7'd10;
    assign w_on   = w_sub8[3:0];

    always_comb begin
        w_mask            = '0;
        w_mask[SLOT_NEG]  = r7_neg;
        w_mask[SLOT_ZERO] = (r7_th == 4'd0) && (r7_hu == 4'd0) && (r7_te == 4'd0)
                            && (w_on == 4'd0);
        w_mask[SLOT_TH_D] = r7_th != 4'd0;
        w_mask[SLOT_TH_U] = r7_th != 4'd0;
        w_mask[SLOT_GAP1] = (r7_th != 4'd0) && (r7_hu == 4'd0)
                            && ((r7_te != 4'd0) || (w_on != 4'd0));
        w_mask[SLOT_HU_D] = r7_hu != 4'd0;
        w_mask[SLOT_HU_U] = r7_hu != 4'd0;
        w_mask[SLOT_GAP2] = (r7_hu != 4'd0) && (r7_te == 4'd0) && (w_on != 4'd0);
        w_mask[SLOT_TE_D] = r7_te >= 4'd2;
        w_mask[SLOT_TE_U] = r7_te != 4'd0;
        w_mask[SLOT_ON_D] = w_on != 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_neg <= i_value[VALUE_W-1];
            r1_mag <= w_abs;
        end
        if (w_rdy[1]) begin
            r2_neg <= r1_neg;
            r2_mag <= (r1_mag > VALUE_W'(MAG_LIMIT)) ? MAG_LIMIT : r1_mag[MAG_W-1:0];
        end
        if (w_rdy[2]) begin
            r3_neg <= r2_neg;
            r3_mag <= r2_mag;
            r3_th  <= w_p3[27:24];
        end
        if (w_rdy[3]) begin
            r4_neg <= r3_neg;
            r4_th  <= r3_th;
            r4_r1  <= w_sub4[9:0];
        end
        if (w_rdy[4]) begin
            r5_neg <= r4_neg;
            r5_th  <= r4_th;
            r5_r1  <= r4_r1;
            r5_hu  <= w_p5[15:12];
        end
        if (w_rdy[5]) begin
            r6_neg <= r5_neg;
            r6_th  <= r5_th;
            r6_hu  <= r5_hu;
            r6_r2  <= w_sub6[6:0];
        end
        if (w_rdy[6]) begin
            r7_neg <= r6_neg;
            r7_th  <= r6_th;
            r7_hu  <= r6_hu;
            r7_r2  <= r6_r2;
            r7_te  <= w_p7[14:11];
        end
        if (w_rdy[7]) begin
            r8_item.dig.th <= r7_th;
            r8_item.dig.hu <= r7_hu;
            r8_item.dig.te <= r7_te;
            r8_item.dig.on <= w_on;
            r8_item.mask   <= w_mask;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTAGE-1];
    assign o_item  = r8_item;

endmodule

`default_nettype wire

// File: rtl/core/chinese_number_speech_tokens.sv
// Top level of the Chinese numeral reader: digit pipeline plus clip serializer.
// Depends on cnst_pkg and cnst_split.
//
//  channel  | dir | tdata                        | tlast
//  s_axis   | in  | [14:0] value (signed), pad 0 | -
//  m_axis   | out | [7:0] clip_id                | last clip of the number
//
// From input transaction to first clip a value passes the eight stages, then the output reg.
// Each number leaves as 1 to 8 clips, one per cycle while m_axis_tready is high;
// the single output port sets the sustained rate.
// Synchronous active-low reset clears all valid bits and the pending clip mask.
// A stall on m_axis holds the output and backs up the pipeline stage by stage.
`default_nettype none

module chinese_number_speech_tokens import cnst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] value, [15] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] clip_id
    output logic        m_axis_tlast
);

    logic              w_split_valid;
    logic              w_split_ready;
    t_item             w_item;

    logic              r_ovalid;
    logic [CLIP_W-1:0] r_clip;
    logic              r_last;
    logic [NSLOT-1:0]  r_mask;
    t_digits           r_dig;

    logic              w_out_free;
    logic              w_hold;
    logic              w_load;
    logic [NSLOT-1:0]  w_src_mask;
    t_digits           w_src_dig;
    logic [NSLOT-1:0]  w_pick;
    logic [NSLOT-1:0]  n_mask;
    logic [CLIP_W-1:0] w_clip;

    cnst_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_value (s_axis_tdata[VALUE_W-1:0]),
        .o_ready (s_axis_tready),
        .o_valid (w_split_valid),
        .i_ready (w_split_ready),
        .o_item  (w_item)
    );

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign w_hold        = r_mask != '0;
    assign w_split_ready = w_out_free && !w_hold;
    assign w_load        = w_out_free && (w_hold || w_split_valid);
    assign w_src_mask    = w_hold ? r_mask : w_item.mask;
    assign w_src_dig     = w_hold ? r_dig : w_item.dig;
    assign w_pick        = w_src_mask & (~w_src_mask + NSLOT'(1));
    assign n_mask        = w_src_mask & ~w_pick;

    // lowest pending slot wins
    always_comb begin
        w_clip = CLIP_DIGIT0;
        for (int k = NSLOT - 1; k >= 0; k--) begin
            if (w_src_mask[k]) begin
                w_clip = slot_clip(SLOT_W'(k), w_src_dig);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_mask   <= '0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
            r_mask   <= n_mask;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_clip <= w_clip;
            r_last <= n_mask == '0;
        end
        if (w_load && !w_hold) begin
            r_dig <= w_item.dig;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_clip;
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// File: rtl/core/cnst_checker.sv
// Port-level checker for the numeral reader, bound to the top level.
// Depends on cnst_pkg and chinese_number_speech_tokens_defines.svh.
`default_nettype none

`include "chinese_number_speech_tokens_defines.svh"

module cnst_checker import cnst_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    `CNST_ASSERT_RST(a_rst_idle, (!i_rst_n) |=> !m_axis_tvalid, "output valid after reset")
    `CNST_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled transaction changed")
    `CNST_ASSERT(a_clip_legal, m_axis_tvalid |-> ((m_axis_tdata >= CLIP_DIGIT0 && m_axis_tdata <= CLIP_THOUSAND) || m_axis_tdata == CLIP_NEGATIVE), "illegal clip id")
    `CNST_ASSERT(a_neg_not_last, (m_axis_tvalid && m_axis_tdata == CLIP_NEGATIVE) |-> !m_axis_tlast, "negative clip flagged last")

endmodule

bind chinese_number_speech_tokens cnst_checker u_cnst_checker (.*);

`default_nettype wire

// File: test/chinese_number_speech_tokens_chk.sv
// Checker for the Chinese numeral reader: predicts the clip ID sequence of every accepted
// value and compares each output transaction against it in order.
// Depends on cnst_pkg for widths and clip codes.
`timescale 1ns / 1ps

module chinese_number_speech_tokens_chk import cnst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] value, [15] zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] clip_id
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [CLIP_W-1:0] clip_id;
        logic              last;
    } t_spoken;

    t_spoken spoken_clips[$];
    int      fail_count = 0;

    function automatic void read_aloud(input logic [VALUE_W-1:0] value);
        logic [CLIP_W-1:0] words[$];
        logic              neg;
        int                mag;
        int                th, hu, te, on;
        t_spoken           w;
        neg = value[VALUE_W-1];
        mag = neg ? -int'(signed'(value)) : int'(value);
        if (mag > int'(MAG_LIMIT)) mag = int'(MAG_LIMIT);
        if (neg) words.push_back(CLIP_NEGATIVE);
        if (mag == 0) begin
            words.push_back(CLIP_DIGIT0);
        end else begin
            th = mag / 1000;
            hu = (mag % 1000) / 100;
            te = (mag % 100) / 10;
            on = mag % 10;
            if (th > 0) begin
                words.push_back(CLIP_DIGIT0 + CLIP_W'(th));
                words.push_back(CLIP_THOUSAND);
                if (hu == 0 && (te > 0 || on > 0)) words.push_back(CLIP_DIGIT0);
            end
            if (hu > 0) begin
                words.push_back(CLIP_DIGIT0 + CLIP_W'(hu));
                words.push_back(CLIP_HUNDRED);
                if (te == 0 && on > 0) words.push_back(CLIP_DIGIT0);
            end
            if (te >= 2) begin
                words.push_back(CLIP_DIGIT0 + CLIP_W'(te));
                words.push_back(CLIP_TEN);
            end else if (te == 1) begin
                words.push_back(CLIP_TEN);
            end
            if ((th == 0 && hu == 0 && te == 0) || on > 0)
                words.push_back(CLIP_DIGIT0 + CLIP_W'(on));
        end
        foreach (words[i]) begin
            w.clip_id = words[i];
            w.last    = (i == words.size() - 1);
            spoken_clips.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        t_spoken want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (spoken_clips.size() == 0) begin
                    $error("clip_id expected none actual %0d", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = spoken_clips.pop_front();
                    if (m_axis_tdata !== want.clip_id) begin
                        $error("clip_id expected %0d actual %0d", want.clip_id, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) read_aloud(s_axis_tdata[VALUE_W-1:0]);
        end
        o_pending    <= spoken_clips.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: test/chinese_number_speech_tokens_tb.sv
// Testbench top for the Chinese numeral reader: clock, reset, value stimulus with random
// gaps, random output stalls and the final verdict.
// Depends on cnst_pkg, the block and chinese_number_speech_tokens_chk.
`timescale 1ns / 1ps

module chinese_number_speech_tokens_tb;
    import cnst_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [14:0] value, [15] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] clip_id
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          quiet_left = 0;
    int          ready_hold = 0;

    int directed_values[] = '{0, 1, 9, 10, 11, 19, 20, 99, 100, 101, 105, 110, 1000, 1001,
                              1010, 1050, 1100, 2005, 3070, 9999, 10000, 16383, -1,
                              -110, -9999, -10000, -16384};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    chinese_number_speech_tokens dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    chinese_number_speech_tokens_chk chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_digit();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int mag;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) return VALUE_W'($urandom);
        if (kind == 1) mag = $urandom_range(0, 20);
        else mag = pick_digit() * 1000 + pick_digit() * 100 + pick_digit() * 10 + pick_digit();
        return VALUE_W'(($urandom_range(0, 2) == 0) ? -mag : mag);
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 30);
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // output back-pressure: alternate ready runs and stalls of random length
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(0, 12);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold    <= pick_gap();
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_values[i]) send_value(VALUE_W'(directed_values[i]));
        repeat (385) send_value(random_value());
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cnst_pkg.sv
rtl/core/cnst_split.sv
rtl/core/chinese_number_speech_tokens.sv
rtl/core/cnst_checker.sv
test/chinese_number_speech_tokens_chk.sv
test/chinese_number_speech_tokens_tb.sv
